// ===== sv/dvr_pkg.sv =====
// shared types and constants of the distance vector route engine
package dvr_pkg;

	localparam int MAX_NODES = 8;
	localparam int NODE_W    = 3;
	localparam int CNT_W     = 4;
	localparam int COST_W    = 16;
	localparam int ADDR_W    = 2 * NODE_W;

	localparam logic [COST_W-1:0] INF_COST = '1;

	localparam logic [1:0] CFG_SELF_NODE  = 2'd0;
	localparam logic [1:0] CFG_NODE_COUNT = 2'd1;
	localparam logic [1:0] CFG_NBR_MASK   = 2'd2;
	localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

	typedef enum logic [1:0] {
		ACT_LINK = 2'd0,
		ACT_VEC  = 2'd1,
		ACT_TICK = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		OP_LINK,
		OP_VEC,
		OP_TICK
	} op_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_ACTIVE,
		ST_INACTIVE
	} status_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_EXEC,
		BS_TICK,
		BS_RC_D,
		BS_RC_SCAN,
		BS_RC_WAIT,
		BS_EMIT
	} back_state_t;

	typedef struct packed {
		logic [NODE_W-1:0]    self_node;
		logic [CNT_W-1:0]     n;
		logic [MAX_NODES-1:0] mask;
		logic [15:0]          limit;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] dst;
		logic [COST_W-1:0] cost;
		logic              first;
		logic              last;
	} cmd_t;

endpackage

// ===== sv/distance_vector_route_engine.sv =====
// top level of the distance vector route engine
// A queued command runs in the back end one step at a time. A timer tick steps
// through every node. A recompute walks each of the n destinations with one pair
// of cost matrix reads per node slot (the self node and inactive nodes skip the
// scan), then emits n rows at one per cycle while the output is free. The single
// pair of cost matrix reads per cycle sets the length of a recompute. Up to two
// commands wait in the queue meanwhile.
module distance_vector_route_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [2:0]  source_node,
	input  logic [2:0]  dest_node,
	input  logic [15:0] cost_value,
	input  logic        first_entry,
	input  logic        last_entry,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  route_dest,
	output logic [15:0] route_cost,
	output logic [2:0]  route_hop,
	output logic        route_valid,
	output logic        table_last
);
	import dvr_pkg::*;

	logic [2:0]  self_q;
	logic [3:0]  count_q;
	logic [7:0]  mask_q;
	logic [15:0] timeout_q;
	cfg_t        cfg;
	logic        cmd_valid, cmd_pop;
	cmd_t        cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_q    <= 3'd0;
			count_q   <= 4'd8;
			mask_q    <= 8'd0;
			timeout_q <= 16'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SELF_NODE:  self_q    <= cfg_data[2:0];
				CFG_NODE_COUNT: count_q   <= cfg_data[3:0];
				CFG_NBR_MASK:   mask_q    <= cfg_data[7:0];
				CFG_TIMEOUT:    timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.self_node = self_q;
		cfg.mask      = mask_q;
		cfg.n         = (count_q == 4'd0) ? 4'd1 :
			(count_q > 4'(MAX_NODES)) ? 4'(MAX_NODES) : count_q;
		cfg.limit     = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
	end

	dvr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.source_node (source_node),
		.dest_node   (dest_node),
		.cost_value  (cost_value),
		.first_entry (first_entry),
		.last_entry  (last_entry),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd)
	);

	dvr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.route_dest  (route_dest),
		.route_cost  (route_cost),
		.route_hop   (route_hop),
		.route_valid (route_valid),
		.table_last  (table_last)
	);

endmodule

// ===== sv/dvr_front.sv =====
// front end: accepts input transactions, drops the ones with no effect, queues commands
module dvr_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dvr_pkg::cfg_t           cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              action,
	input  logic [2:0]              source_node,
	input  logic [2:0]              dest_node,
	input  logic [15:0]             cost_value,
	input  logic                    first_entry,
	input  logic                    last_entry,
	output logic                    cmd_valid,
	input  logic                    cmd_pop,
	output dvr_pkg::cmd_t           cmd
);
	import dvr_pkg::*;

	cmd_t       q_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       push;
	cmd_t       cls;

	always_comb begin
		cls.src   = source_node;
		cls.dst   = dest_node;
		cls.cost  = cost_value;
		cls.first = first_entry;
		cls.last  = last_entry;
		cls.op    = OP_TICK;
		keep      = 1'b0;
		case (action_t'(action))
			ACT_LINK: begin
				cls.op = OP_LINK;
				keep   = {1'b0, source_node} < cfg.n;
			end
			ACT_VEC: begin
				cls.op = OP_VEC;
				keep   = ({1'b0, source_node} < cfg.n) && ({1'b0, dest_node} < cfg.n)
					&& (source_node != cfg.self_node);
			end
			ACT_TICK: begin
				cls.op = OP_TICK;
				keep   = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign in_ready  = cnt_q != 2'd2;
	assign push      = in_valid && in_ready && keep;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (cmd_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

endmodule

// ===== sv/dvr_back.sv =====
// back end: cost matrix, node state, route recompute and table emission
module dvr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  dvr_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	input  dvr_pkg::cmd_t cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    route_dest,
	output logic [15:0]   route_cost,
	output logic [2:0]    route_hop,
	output logic          route_valid,
	output logic          table_last
);
	import dvr_pkg::*;

	back_state_t state_q, state_d;
	cmd_t        cmd_q;
	logic [NODE_W-1:0] idx_q, j_q;
	logic        changed_q;
	logic [COST_W-1:0] best_q;
	logic [NODE_W-1:0] hop_q;
	logic        found_q;

	status_t     status_q [MAX_NODES];
	logic [15:0] age_q [MAX_NODES];
	logic [COST_W-1:0] rcost_q [MAX_NODES];
	logic [NODE_W-1:0] rhop_q [MAX_NODES];
	logic [MAX_NODES-1:0] rvld_q;

	logic [COST_W-1:0] mem [MAX_NODES*MAX_NODES];
	logic [MAX_NODES*MAX_NODES-1:0] vld_q;
	logic [MAX_NODES-1:0] clr_q;

	logic              v_s1, a_use_s1, b_use_s1;
	logic [NODE_W-1:0] j_s1;
	logic [COST_W-1:0] a_mem_s1, b_mem_s1, a_def_s1, b_def_s1;

	logic              out_v_q;
	logic [2:0]        dest_q, hop_o_q;
	logic [15:0]       cost_o_q;
	logic              rv_o_q, last_o_q;

	logic idx_last, j_last, self_ok, self_hit, nb_idx, active_nb, timeout;
	logic [15:0] age_next;
	status_t st_cur;
	logic [ADDR_W-1:0] addr_a, addr_b;
	logic [COST_W-1:0] a_val, b_val, sum_sat, fin_best;
	logic [COST_W:0]   sum;
	logic take;
	logic [NODE_W-1:0] fin_hop;
	logic fin_found;

	logic              mem_we, row_clr, issue, rt_we, st_we, age_we, emit, idx_step;
	logic [ADDR_W-1:0] mem_waddr;
	logic [COST_W-1:0] mem_wdata, rt_cost;
	logic [NODE_W-1:0] rt_hop;
	logic              rt_vld;
	status_t           st_val;
	logic [15:0]       age_val;

	function automatic logic [COST_W-1:0] reset_val(input logic [ADDR_W-1:0] a,
		input logic cleared);
		logic [COST_W-1:0] v;
		v = INF_COST;
		if (!cleared && a[ADDR_W-1:NODE_W] == a[NODE_W-1:0]) begin
			v = '0;
		end
		return v;
	endfunction

	assign idx_last  = {1'b0, idx_q} == cfg.n - 4'd1;
	assign j_last    = {1'b0, j_q} == cfg.n - 4'd1;
	assign self_ok   = {1'b0, cfg.self_node} < cfg.n;
	assign self_hit  = self_ok && idx_q == cfg.self_node;
	assign st_cur    = status_q[idx_q];
	assign nb_idx    = idx_q != cfg.self_node && cfg.mask[idx_q];
	assign active_nb = st_cur == ST_ACTIVE && nb_idx;
	assign age_next  = (age_q[idx_q] == 16'hFFFF) ? age_q[idx_q] : age_q[idx_q] + 16'd1;
	assign timeout   = active_nb && age_next >= cfg.limit;

	assign addr_a = {cfg.self_node, j_q};
	assign addr_b = {j_q, idx_q};

	// compare stage on registered matrix reads
	assign a_val   = a_use_s1 ? a_mem_s1 : a_def_s1;
	assign b_val   = b_use_s1 ? b_mem_s1 : b_def_s1;
	assign sum     = {1'b0, a_val} + {1'b0, b_val};
	assign sum_sat = (sum >= {1'b0, INF_COST}) ? INF_COST : sum[COST_W-1:0];
	assign take    = v_s1 && self_ok && j_s1 != cfg.self_node && cfg.mask[j_s1]
		&& a_val != INF_COST && b_val != INF_COST && sum_sat < best_q;
	assign fin_best  = take ? sum_sat : best_q;
	assign fin_hop   = take ? j_s1 : hop_q;
	assign fin_found = take || found_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (cmd_valid) begin
					state_d = BS_EXEC;
				end
			end
			BS_EXEC: begin
				case (cmd_q.op)
					OP_LINK: state_d = BS_RC_D;
					OP_VEC: begin
						if (st_cur == ST_INACTIVE || !cmd_q.last) begin
							state_d = BS_IDLE;
						end else begin
							state_d = BS_RC_D;
						end
					end
					OP_TICK: state_d = BS_TICK;
					default: state_d = BS_IDLE;
				endcase
			end
			BS_TICK: begin
				if (idx_last) begin
					state_d = (changed_q || timeout) ? BS_RC_D : BS_IDLE;
				end
			end
			BS_RC_D: begin
				if (self_hit || st_cur == ST_INACTIVE) begin
					state_d = idx_last ? BS_EMIT : BS_RC_D;
				end else begin
					state_d = BS_RC_SCAN;
				end
			end
			BS_RC_SCAN: begin
				if (j_last) begin
					state_d = BS_RC_WAIT;
				end
			end
			BS_RC_WAIT: state_d = idx_last ? BS_EMIT : BS_RC_D;
			BS_EMIT: begin
				if (emit && idx_last) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = {cfg.self_node, idx_q};
		mem_wdata = INF_COST;
		row_clr   = 1'b0;
		issue     = 1'b0;
		rt_we     = 1'b0;
		rt_cost   = INF_COST;
		rt_hop    = '0;
		rt_vld    = 1'b0;
		st_we     = 1'b0;
		st_val    = st_cur;
		age_we    = 1'b0;
		age_val   = '0;
		emit      = 1'b0;
		idx_step  = 1'b0;
		case (state_q)
			BS_IDLE: cmd_pop = cmd_valid;
			BS_EXEC: begin
				case (cmd_q.op)
					OP_LINK: begin
						mem_we    = 1'b1;
						mem_waddr = {cfg.self_node, cmd_q.src};
						mem_wdata = cmd_q.cost;
					end
					OP_VEC: begin
						if (st_cur != ST_INACTIVE) begin
							mem_we    = 1'b1;
							mem_waddr = {cmd_q.src, cmd_q.dst};
							mem_wdata = cmd_q.cost;
							row_clr   = cmd_q.first;
							age_we    = 1'b1;
							if (cmd_q.first && st_cur == ST_INIT) begin
								st_we  = 1'b1;
								st_val = ST_ACTIVE;
							end
						end
					end
					default: ;
				endcase
			end
			BS_TICK: begin
				idx_step = 1'b1;
				if (active_nb) begin
					age_we  = 1'b1;
					age_val = age_next;
				end
				if (timeout) begin
					st_we  = 1'b1;
					st_val = ST_INACTIVE;
					mem_we = 1'b1;
					rt_we  = 1'b1;
				end
			end
			BS_RC_D: begin
				if (self_hit) begin
					rt_we   = 1'b1;
					rt_cost = '0;
					rt_hop  = cfg.self_node;
					rt_vld  = 1'b1;
				end
				idx_step = self_hit || st_cur == ST_INACTIVE;
			end
			BS_RC_SCAN: issue = 1'b1;
			BS_RC_WAIT: begin
				rt_we    = 1'b1;
				rt_cost  = fin_best;
				rt_hop   = fin_hop;
				rt_vld   = fin_found;
				idx_step = 1'b1;
			end
			BS_EMIT: begin
				emit     = !out_v_q || out_ready;
				idx_step = emit;
			end
			default: ;
		endcase
	end

	// cost matrix storage, registered matrix reads, route table and output registers
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		a_mem_s1 <= mem[addr_a];
		b_mem_s1 <= mem[addr_b];
		a_def_s1 <= reset_val(addr_a, clr_q[cfg.self_node]);
		b_def_s1 <= reset_val(addr_b, clr_q[j_q]);
		j_s1     <= j_q;
		if (state_q == BS_IDLE) begin
			cmd_q <= cmd;
		end
		if (rt_we) begin
			rcost_q[idx_q] <= rt_cost;
			rhop_q[idx_q]  <= rt_hop;
		end
		if (age_we) begin
			age_q[idx_q] <= age_val;
		end
		if (state_q == BS_RC_D) begin
			best_q  <= INF_COST;
			hop_q   <= '0;
			found_q <= 1'b0;
		end else if (take) begin
			best_q  <= sum_sat;
			hop_q   <= j_s1;
			found_q <= 1'b1;
		end
		if (emit) begin
			dest_q   <= idx_q;
			cost_o_q <= rcost_q[idx_q];
			hop_o_q  <= rvld_q[idx_q] ? rhop_q[idx_q] : 3'd0;
			rv_o_q   <= rvld_q[idx_q];
			last_o_q <= idx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BS_IDLE;
			idx_q     <= '0;
			j_q       <= '0;
			changed_q <= 1'b0;
			v_s1      <= 1'b0;
			a_use_s1  <= 1'b0;
			b_use_s1  <= 1'b0;
			vld_q     <= '0;
			clr_q     <= '0;
			out_v_q   <= 1'b0;
			rvld_q    <= {{(MAX_NODES-1){1'b0}}, 1'b1};
			for (int i = 0; i < MAX_NODES; i++) begin
				status_q[i] <= ST_INIT;
			end
		end else begin
			state_q  <= state_d;
			v_s1     <= issue;
			a_use_s1 <= vld_q[addr_a];
			b_use_s1 <= vld_q[addr_b];
			if (row_clr) begin
				clr_q[cmd_q.src] <= 1'b1;
				for (int c = 0; c < MAX_NODES; c++) begin
					vld_q[{cmd_q.src, NODE_W'(c)}] <= 1'b0;
				end
			end
			if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end
			if (st_we) begin
				status_q[idx_q] <= st_val;
			end
			if (rt_we) begin
				rvld_q[idx_q] <= rt_vld;
			end
			if (state_q == BS_IDLE && cmd_valid) begin
				idx_q <= cmd.src;
			end else if (state_q == BS_EXEC) begin
				idx_q <= '0;
			end else if (idx_step) begin
				idx_q <= idx_last ? '0 : idx_q + 3'd1;
			end
			if (state_q == BS_RC_D) begin
				j_q <= '0;
			end else if (issue) begin
				j_q <= j_q + 3'd1;
			end
			if (state_q == BS_EXEC) begin
				changed_q <= 1'b0;
			end else if (timeout && state_q == BS_TICK) begin
				changed_q <= 1'b1;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_v_q;
	assign route_dest  = dest_q;
	assign route_cost  = cost_o_q;
	assign route_hop   = hop_o_q;
	assign route_valid = rv_o_q;
	assign table_last  = last_o_q;

endmodule

// ===== sv/dvr_checker.sv =====
// port level checks of the route engine and their binding
module dvr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  route_dest,
	input logic [15:0] route_cost,
	input logic [2:0]  route_hop,
	input logic        route_valid,
	input logic        table_last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(route_dest)
		&& $stable(route_cost) && $stable(table_last))
		else $error("result changed while stalled");

	a_new_table: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && table_last |=> !out_valid || route_dest == 3'd0)
		else $error("table does not start at node zero");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && route_dest == 3'd7 |-> table_last)
		else $error("row seven not marked last");

	a_no_hop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !route_valid |-> route_hop == 3'd0)
		else $error("next hop set without a route");

endmodule

bind distance_vector_route_engine dvr_checker u_dvr_checker (.*);
